// File: rtl/ps2_mouse_packet_assembler_defines.svh
// assertion macros for the ps2 mouse packet assembler
`ifndef PS2_MOUSE_PACKET_ASSEMBLER_DEFINES_SVH
`define PS2_MOUSE_PACKET_ASSEMBLER_DEFINES_SVH

`ifndef SYNTH
`define PS2M_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("ps2m assertion failed");
`define PS2M_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("ps2m assertion failed");
`else
`define PS2M_ASSERT(label, clk, rst, prop)
`define PS2M_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

// File: rtl/ps2m_pkg.sv
// shared types and constants for the ps2 mouse packet assembler
package ps2m_pkg;

   localparam logic [15:0] TIMEOUT_RESET = 16'd500;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_PACKET  = 2'd0,
      STATUS_ALIGN   = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef struct packed {
      status_type        status;
      logic signed [8:0] move_x;
      logic signed [8:0] move_y;
      logic              x_ovf;
      logic              y_ovf;
      logic              button_left;
      logic              button_right;
      logic              button_middle;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type result;
   } step_out_type;

endpackage

// File: rtl/ps2m_in_stage.sv
// input register for received bytes and timer ticks
module ps2m_in_stage import ps2m_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // rx_byte[7:0]
   input  logic       req_tuser,   // cmd
   input  logic       take,
   output logic       in_valid,
   output logic       in_cmd,
   output logic [7:0] in_byte
);

   logic       valid_ff, valid_in;
   logic       cmd_ff, cmd_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = load ? 1'b1 : (take ? 1'b0 : valid_ff);
      cmd_in   = load ? req_tuser : cmd_ff;
      byte_in  = load ? req_tdata : byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff  <= cmd_in;
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_cmd   = cmd_ff;
   assign in_byte  = byte_ff;

endmodule

// File: rtl/ps2m_decoder.sv
// packet state, timeout register and decode logic
module ps2m_decoder import ps2m_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [15:0]  csr_data,
   input  logic         step,
   input  logic         in_cmd,
   input  logic [7:0]   in_byte,
   output step_out_type step_out
);

`include "ps2_mouse_packet_assembler_defines.svh"

   logic [15:0] timeout_ff, timeout_in;
   logic [1:0]  pos_ff, pos_in;
   logic [7:0]  status_byte_ff, status_byte_in;
   logic [7:0]  x_byte_ff, x_byte_in;
   logic [15:0] idle_ff, idle_in;
   logic        armed_ff, armed_in;
   logic [15:0] limit;
   logic [15:0] idle_next;

   assign timeout_in = csr_valid ? csr_data : timeout_ff;
   assign limit      = (timeout_ff == 16'd0) ? 16'd1 : timeout_ff;
   assign idle_next  = (idle_ff < COUNT_MAX) ? idle_ff + 16'd1 : idle_ff;

   always_comb begin
      pos_in         = pos_ff;
      status_byte_in = status_byte_ff;
      x_byte_in      = x_byte_ff;
      idle_in        = idle_ff;
      armed_in       = armed_ff;
      step_out       = '0;
      step_out.result.status = STATUS_PACKET;
      if (step) begin
         if (in_cmd == CMD_TICK) begin
            if (armed_ff) begin
               if (idle_next >= limit) begin
                  pos_in         = 2'd0;
                  status_byte_in = 8'd0;
                  x_byte_in      = 8'd0;
                  idle_in        = 16'd0;
                  armed_in       = 1'b0;
                  step_out.valid = 1'b1;
                  step_out.result.status = STATUS_TIMEOUT;
               end else begin
                  idle_in = idle_next;
               end
            end
         end else begin
            idle_in  = 16'd0;
            armed_in = 1'b0;
            unique case (pos_ff)
               2'd1: begin
                  x_byte_in = in_byte;
                  pos_in    = 2'd2;
                  armed_in  = 1'b1;
               end
               2'd2: begin
                  step_out.valid                = 1'b1;
                  // sign bits live in the first byte
                  step_out.result.move_x        = {status_byte_ff[4], x_byte_ff};
                  step_out.result.move_y        = {status_byte_ff[5], in_byte};
                  step_out.result.x_ovf         = status_byte_ff[6];
                  step_out.result.y_ovf         = status_byte_ff[7];
                  step_out.result.button_left   = status_byte_ff[0];
                  step_out.result.button_right  = status_byte_ff[1];
                  step_out.result.button_middle = status_byte_ff[2];
                  pos_in         = 2'd0;
                  status_byte_in = 8'd0;
                  x_byte_in      = 8'd0;
               end
               default: begin
                  if (!in_byte[3]) begin
                     pos_in         = 2'd0;
                     status_byte_in = 8'd0;
                     x_byte_in      = 8'd0;
                     step_out.valid = 1'b1;
                     step_out.result.status = STATUS_ALIGN;
                  end else begin
                     status_byte_in = in_byte;
                     x_byte_in      = 8'd0;
                     pos_in         = 2'd1;
                     armed_in       = 1'b1;
                  end
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff     <= TIMEOUT_RESET;
         pos_ff         <= 2'd0;
         status_byte_ff <= 8'd0;
         x_byte_ff      <= 8'd0;
         idle_ff        <= 16'd0;
         armed_ff       <= 1'b0;
      end else begin
         timeout_ff     <= timeout_in;
         pos_ff         <= pos_in;
         status_byte_ff <= status_byte_in;
         x_byte_ff      <= x_byte_in;
         idle_ff        <= idle_in;
         armed_ff       <= armed_in;
      end
   end

   `PS2M_ASSERT(a_pos_range, clock, reset, pos_ff != 2'd3)
   `PS2M_ASSERT(a_armed_partial, clock, reset, armed_ff == (pos_ff != 2'd0))
   `PS2M_ASSERT(a_idle_unarmed, clock, reset, (idle_ff != 16'd0) |-> armed_ff)
   `PS2M_ASSERT_NEXT(a_result_clears, clock, reset, step_out.valid, pos_ff == 2'd0)

endmodule

// File: rtl/ps2m_out_stage.sv
// result register towards the master side
module ps2m_out_stage import ps2m_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  step_out_type step_out,
   output logic         out_busy,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,  // move_x[8:0], move_y[8:0], x_ovf, y_ovf,
                                    // button_left, button_right, button_middle, zero pad
   output logic [1:0]   rsp_tuser   // status
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   always_comb begin
      if (load && step_out.valid) begin
         valid_in = 1'b1;
         res_in   = step_out.result;
      end else begin
         valid_in = rsp_tready ? 1'b0 : valid_ff;
         res_in   = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign out_busy   = valid_ff && !rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {1'b0, res_ff.button_middle, res_ff.button_right,
                        res_ff.button_left, res_ff.y_ovf, res_ff.x_ovf,
                        res_ff.move_y, res_ff.move_x};

endmodule

// File: rtl/ps2_mouse_packet_assembler.sv
// Assembles three-byte PS/2 mouse movement packets from a stream of received bytes and
// timer ticks. Each beat on req_ carries either a byte (tuser 0) or a tick (tuser 1); a
// beat is taken every cycle while the result register is free or being drained, and it
// passes from the input register through one level of decode into the result register,
// which drives rsp_tvalid. Only the third byte of a packet, a first byte with bit 3
// clear, or a partial packet that sees timeout_ticks ticks without a byte yields a
// result beat; the user must write the timeout on csr_ only while idle, as the block
// itself does not enforce it.
module ps2_mouse_packet_assembler import ps2m_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,   // timeout_ticks
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // rx_byte[7:0]
   input  logic        req_tuser,  // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // move_x[8:0], move_y[8:0], x_ovf, y_ovf,
                                   // button_left, button_right, button_middle, zero pad
   output logic [1:0]  rsp_tuser   // status
);

   logic         in_valid;
   logic         in_cmd;
   logic [7:0]   in_byte;
   logic         out_busy;
   logic         step;
   step_out_type step_out;

   assign csr_ready = 1'b1;
   assign step      = in_valid && !out_busy;

   ps2m_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (step),
      .in_valid   (in_valid),
      .in_cmd     (in_cmd),
      .in_byte    (in_byte)
   );

   ps2m_decoder u_dec (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .step      (step),
      .in_cmd    (in_cmd),
      .in_byte   (in_byte),
      .step_out  (step_out)
   );

   ps2m_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .step_out   (step_out),
      .out_busy   (out_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
